// File: rtl/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Types and fixed constants shared by the merge sorter and its cells.
// ----------------------------------------------------------------------------
package msort_pkg;

   // Width of the value fields on the ports
   localparam int WORD_WIDTH = 32;
   // Widest internal word: covers data widths up to 64 bits and the port width
   localparam int EXT_WIDTH  = 64;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] value;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] value_res;
      logic                         last_res;
   } rsp_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   // Status one cell hands to its right neighbor
   typedef struct packed {
      logic valid;   // cell holds an element
      logic lt;      // incoming element sorts before this cell's element, or cell is empty
   } cell_flag_type;

endpackage

// File: rtl/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter
// Batch sorter: collects signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while busy is low; each item is placed in
// order as it arrives. Output: the first result appears the cycle after the
// item flagged last is taken; the results follow back to back, busy high
// throughout, with the one-slot-per-cycle shift of the cell row moving
// each into cell 0. The receiver cannot stall.
// Reset (synchronous) empties every cell and the item count.
// ----------------------------------------------------------------------------
module merge_sorter #(
   parameter int MAX_ITEMS  = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msort_pkg::req_type req_item,
   output logic               rsp_strobe,
   output msort_pkg::rsp_type rsp_item
);

   localparam int CntW = $clog2(MAX_ITEMS + 1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic [0:0]      state_ff;
   logic [0:0]      state_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic [CntW-1:0] remain_ff;
   logic [CntW-1:0] remain_in;

   logic accept;
   logic store_ok;

   msort_pkg::cell_cmd_type cmd;

   logic [msort_pkg::EXT_WIDTH-1:0] in_ext;
   logic [msort_pkg::EXT_WIDTH-1:0] out_ext;
   logic [DATA_WIDTH-1:0]           new_value;

   // Per-cell links along the row
   logic [DATA_WIDTH-1:0]    cell_value [MAX_ITEMS];
   msort_pkg::cell_flag_type cell_flag  [MAX_ITEMS];

   // ---------------------------------------------------------------------
   // Input side: take an item whenever idle; drop it once the row is full
   // ---------------------------------------------------------------------
   assign busy     = (state_ff == ST_DRAIN);
   assign accept   = start && !busy;
   assign store_ok = (count_ff < CntW'(MAX_ITEMS));

   // Keep the low DATA_WIDTH bits of the value, zero-extended if wider
   assign in_ext    = {{(msort_pkg::EXT_WIDTH - msort_pkg::WORD_WIDTH){1'b0}},
                       req_item.value};
   assign new_value = in_ext[DATA_WIDTH-1:0];

   assign cmd.insert = accept && store_ok;
   assign cmd.shift  = busy;

   // ---------------------------------------------------------------------
   // Control: count the batch, then drain it one element per cycle
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.last) begin
                  // Hand the whole batch over to the output side
                  remain_in = count_ff + CntW'(store_ok);
                  count_in  = '0;
                  state_in  = ST_DRAIN;
               end else begin
                  count_in = count_ff + CntW'(store_ok);
               end
            end
         end
         ST_DRAIN: begin
            remain_in = remain_ff - CntW'(1);
            if (remain_ff == CntW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   // ---------------------------------------------------------------------
   // Row of cells, smallest element in cell 0. Insert places the new item
   // in order; shift moves everything one cell toward cell 0.
   // ---------------------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
         msort_pkg::cell_flag_type prev_flag;
         logic [DATA_WIDTH-1:0]    prev_value;
         logic                     next_valid;
         logic [DATA_WIDTH-1:0]    next_value;

         if (gi == 0) begin : g_head
            // Nothing sorts before the head: new item lands here if smaller
            assign prev_flag.valid = 1'b1;
            assign prev_flag.lt    = 1'b0;
            assign prev_value      = '0;
         end else begin : g_body
            assign prev_flag  = cell_flag[gi-1];
            assign prev_value = cell_value[gi-1];
         end

         if (gi == MAX_ITEMS - 1) begin : g_tail
            // Shift an empty slot in at the far end
            assign next_valid = 1'b0;
            assign next_value = '0;
         end else begin : g_inner
            assign next_valid = cell_flag[gi+1].valid;
            assign next_value = cell_value[gi+1];
         end

         msort_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .new_value  (new_value),
            .prev_flag  (prev_flag),
            .prev_value (prev_value),
            .next_valid (next_valid),
            .next_value (next_value),
            .own_value  (cell_value[gi]),
            .own_flag   (cell_flag[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Output: the head cell is the next result; sign-extend to port width
   // ---------------------------------------------------------------------
   assign out_ext = msort_pkg::EXT_WIDTH'(signed'(cell_value[0]));

   assign rsp_strobe         = busy;
   assign rsp_item.value_res = out_ext[msort_pkg::WORD_WIDTH-1:0];
   assign rsp_item.last_res  = (remain_ff == CntW'(1));

endmodule

// File: rtl/msort_cell.sv
// ----------------------------------------------------------------------------
// msort_cell
// One slot of the sorting row: holds one element, inserts in order, shifts.
// ----------------------------------------------------------------------------
module msort_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msort_pkg::cell_cmd_type       cmd,
   input  logic [DATA_WIDTH-1:0]         new_value,
   input  msort_pkg::cell_flag_type      prev_flag,
   input  logic [DATA_WIDTH-1:0]         prev_value,
   input  logic                          next_valid,
   input  logic [DATA_WIDTH-1:0]         next_value,
   output logic [DATA_WIDTH-1:0]         own_value,
   output msort_pkg::cell_flag_type      own_flag
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  new_lt;

   // Empty slots count as larger than anything; equal values stay put
   assign new_lt = !valid_ff || ($signed(new_value) < $signed(value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.shift) begin
         valid_in = next_valid;
         value_in = next_value;
      end else if (cmd.insert && new_lt) begin
         if (prev_flag.lt) begin
            valid_in = prev_flag.valid;
            value_in = prev_value;
         end else begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign own_value      = value_ff;
   assign own_flag.valid = valid_ff;
   assign own_flag.lt    = new_lt;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for merge_sorter. A short table of directed batches
// (after reset, extreme values, ties, a full and an overfull batch) is
// followed by random batches. Every accepted item goes into a local sorting
// predictor; each strobed result is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

   import msort_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 300;
   // Past this many random items, the items are sent without gaps
   localparam int QUIET_AFTER  = 250;

   // One row of the directed table. A row sends run_len items: value,
   // value-1, value-2, ... and flags the final one as last when last is set.
   // Typed rows are single-item batches whose result is written in directly.
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] value;
      logic                         last;
      logic [7:0]                   run_len;
      logic                         typed;
      logic signed [WORD_WIDTH-1:0] typed_value;
   } stim_row_type;

   localparam int PLAN_ROWS = 15;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Values of the batch being collected, as the block should hold them
   logic signed [WORD_WIDTH-1:0] held_vals [CAPACITY];
   int                           held_count = 0;

   // Results of the batch just closed by the predictor
   rsp_type sorted_batch [$];
   // Sorted results still owed by the block, oldest first
   rsp_type sorted_due [$];

   int errors         = 0;
   int batches_closed = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int overfull_seen  = 0;
   int widest_batch   = 0;

   stim_row_type plan [PLAN_ROWS] = '{
      // first batch after reset: a lone zero
      '{32'sh0000_0000, 1'b1, 8'd1,  1'b1, 32'sh0000_0000},
      // lone extremes and all-ones
      '{32'sh7fff_ffff, 1'b1, 8'd1,  1'b1, 32'sh7fff_ffff},
      '{32'sh8000_0000, 1'b1, 8'd1,  1'b1, 32'sh8000_0000},
      '{32'shffff_ffff, 1'b1, 8'd1,  1'b1, 32'shffff_ffff},
      // two-item batch: largest first, smallest last
      '{32'sh7fff_ffff, 1'b0, 8'd1,  1'b0, 32'sh0},
      '{32'sh8000_0000, 1'b1, 8'd1,  1'b0, 32'sh0},
      // ties around a negative value
      '{32'sh0000_0003, 1'b0, 8'd1,  1'b0, 32'sh0},
      '{32'sh0000_0003, 1'b0, 8'd1,  1'b0, 32'sh0},
      '{-32'sd5,        1'b0, 8'd1,  1'b0, 32'sh0},
      '{32'sh0000_0003, 1'b1, 8'd1,  1'b0, 32'sh0},
      // strictly descending run crossing zero
      '{32'sh0000_0004, 1'b1, 8'd8,  1'b0, 32'sh0},
      // exactly full batch
      '{32'sh0000_03e8, 1'b1, 8'd64, 1'b0, 32'sh0},
      // overfull batch: the item flagged last is dropped but closes it
      '{-32'sd20,       1'b1, 8'd67, 1'b0, 32'sh0},
      // alternating bit patterns
      '{32'sh5555_5555, 1'b0, 8'd3,  1'b0, 32'sh0},
      '{32'shaaaa_aaaa, 1'b1, 8'd1,  1'b0, 32'sh0}
   };

   merge_sorter #(
      .MAX_ITEMS  (CAPACITY),
      .DATA_WIDTH (WORD_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #6 clock = ~clock;

   // Fold one accepted item into the predictor. Store it while there is room;
   // on last, sort what is held (stable, ascending, signed), emit the batch
   // into sorted_batch and empty the store.
   task automatic absorb_item(input req_type it);
      logic signed [WORD_WIDTH-1:0] pick;
      int                           j;
      rsp_type                      out;
      sorted_batch.delete();
      if (held_count < CAPACITY) begin
         held_vals[held_count] = it.value;
         held_count++;
      end else if (it.last) begin
         overfull_seen++;
      end
      if (it.last) begin
         // insertion sort keeps equal values in arrival order
         for (int i = 1; i < held_count; i++) begin
            pick = held_vals[i];
            j    = i - 1;
            while (j >= 0 && held_vals[j] > pick) begin
               held_vals[j+1] = held_vals[j];
               j--;
            end
            held_vals[j+1] = pick;
         end
         for (int k = 0; k < held_count; k++) begin
            out.value_res = held_vals[k];
            out.last_res  = (k == held_count - 1);
            sorted_batch.push_back(out);
         end
         if (held_count > widest_batch) widest_batch = held_count;
         batches_closed++;
         held_count = 0;
      end
   endtask

   // Offer one item and hold it until the block takes it. An optional gap
   // of start low comes first. Returns on the edge that accepted the item.
   task automatic send_item(input req_type it, input bit gaps_on,
                            input bit typed, input logic signed [WORD_WIDTH-1:0] typed_val);
      rsp_type fixed;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      // accepted at the first edge with busy low
      do @(posedge clock); while (busy);
      items_sent++;
      absorb_item(it);
      if (typed && it.last) begin
         // result written into the table stands in for the predictor's
         fixed.value_res = typed_val;
         fixed.last_res  = 1'b1;
         sorted_due.push_back(fixed);
      end else begin
         foreach (sorted_batch[k]) sorted_due.push_back(sorted_batch[k]);
      end
   endtask

   // Random value: mostly full-range, plus clusters of small values that
   // force ties and a share of the two extremes.
   function automatic logic signed [WORD_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0, 1:    return $signed($urandom_range(0, 8)) - 4;
         2:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         3:       return $signed($urandom_range(0, 255)) - 128;
         default: return $urandom;
      endcase
   endfunction

   // Check every strobed result against the oldest expected one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (sorted_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value_res=%0d last_res=%0b",
                     $time, rsp_item.value_res, rsp_item.last_res);
         end else begin
            want = sorted_due.pop_front();
            if (rsp_item.value_res !== want.value_res) begin
               errors++;
               $display("%0t: value_res expected %0d, got %0d",
                        $time, want.value_res, rsp_item.value_res);
            end
            if (rsp_item.last_res !== want.last_res) begin
               errors++;
               $display("%0t: last_res expected %0b, got %0b",
                        $time, want.last_res, rsp_item.last_res);
            end
         end
      end
   end

   initial begin
      req_type it;
      int      batch_len;
      int      random_sent;
      random_sent = 0;

      // hold reset from time zero, then release it on an edge
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: walk each row, expanding runs into items
      foreach (plan[r]) begin
         for (int i = 0; i < plan[r].run_len; i++) begin
            it.value = plan[r].value - i;
            it.last  = plan[r].last && (i == plan[r].run_len - 1);
            send_item(it, 1'b1, plan[r].typed, plan[r].typed_value);
         end
      end

      // random batches: mostly short, some large, a few past capacity
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    batch_len = $urandom_range(9, CAPACITY);
            2:       batch_len = ($urandom_range(0, 2) == 0) ?
                                 $urandom_range(CAPACITY + 1, CAPACITY + 6) : CAPACITY;
            default: batch_len = $urandom_range(1, 8);
         endcase
         for (int i = 0; i < batch_len; i++) begin
            it.value = pick_value();
            it.last  = (i == batch_len - 1);
            send_item(it, random_sent < QUIET_AFTER, 1'b0, '0);
            random_sent++;
         end
      end
      start <= 1'b0;

      // drain: wait for every owed result, then a short tail for strays
      wait (sorted_due.size() == 0);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("covered %0d items in %0d batches, %0d results checked",
               items_sent, batches_closed, results_seen);
      $display("widest batch %0d, overfull batches with dropped last %0d",
               widest_batch, overfull_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
